FILE: hdl/hex_record_stream_checker_top_assert.svh
// assertion macros for the hex record stream checker
// used by hex_record_stream_checker_top, no other dependencies
`ifndef HEX_RECORD_STREAM_CHECKER_TOP_ASSERT_SVH
`define HEX_RECORD_STREAM_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HRSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define HRSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/hrsc_pkg.sv
// shared types and constants for the hex record stream checker
// no dependencies
package hrsc_pkg;

   localparam logic [7:0] COLON_CHAR = 8'h3A;
   localparam logic [7:0] TYPE_LIMIT = 8'd6;
   localparam logic [7:0] TYPE_END   = 8'd1;

   typedef enum logic [2:0] {
      PH_COLON = 3'd0,
      PH_COUNT = 3'd1,
      PH_ADDR  = 3'd2,
      PH_TYPE  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CSUM  = 3'd5,
      PH_TERM  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_END     = 3'd1,
      ST_CLEAN   = 3'd2,
      ST_NOCOLON = 3'd3,
      ST_BADTYPE = 3'd4,
      ST_CSUM    = 3'd5,
      ST_TRUNC   = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] record_number;
      logic [7:0]  record_kind;
      logic [15:0] load_address;
      logic [7:0]  byte_count;
   } rsp_type;

endpackage

FILE: hdl/hex_record_stream_checker_top.sv
// hex record stream checker, top level and only module
// depends on hrsc_pkg and hex_record_stream_checker_top_assert.svh
//
// usage:
//  - req channel: one character (or an end-of-input marker) per transfer
//  - rsp channel: one report per finished record, per error and at clean end
//  - the parser state updates at the edge a req transfer happens; a report
//    it raises is registered at that same edge, in the rsp output register
//    or, if that register is held by a stalled receiver, in the skid register
//  - throughput is one character per cycle while req_stall is low, set by
//    the parser step; no character needs more than one pass
//  - a two-entry output (result register plus skid register) lets the parser
//    keep taking characters while a report waits on a stalled receiver;
//    req_stall rises only once both entries are full
//  - after an end record, a clean end or any error, characters are still
//    taken but give no reports until reset
//  - reset (synchronous, active high) returns the parser to waiting for a
//    colon, clears the record counter and empties the output
module hex_record_stream_checker_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hrsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrsc_pkg::rsp_type rsp_data
);
   import hrsc_pkg::*;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [1:0]  digit_ff, digit_in;
   logic [3:0]  high_ff, high_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] address_ff, address_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] seen_ff, seen_in;
   logic        halted_ff, halted_in;

   // output register and skid register
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   rsp_type     skid_ff, skid_in;

   // step results
   logic        req_fire;
   logic        rsp_fire;
   logic        res_valid;
   status_type  res_status;
   logic        res_fields;
   rsp_type     res;
   logic [3:0]  nib;
   logic [7:0]  byte_val;
   logic [15:0] addr_shift;

   // hex digit value (0-9 and upper case A-F only), anything else counts as zero
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end
      return v;
   endfunction

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign nib        = nibble_of(req_data.ch);
   assign byte_val   = {high_ff, nib};
   assign addr_shift = {address_ff[11:0], nib};

   // one parser step per accepted character
   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      high_in    = high_ff;
      count_in   = count_ff;
      address_in = address_ff;
      type_in    = type_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      seen_in    = seen_ff;
      halted_in  = halted_ff;
      res_valid  = 1'b0;
      res_status = ST_OK;
      res_fields = 1'b1;
      if (req_fire && !halted_ff) begin
         unique case (phase_ff)
            PH_TERM: begin
               // one terminator character closes a good record
               if (req_data.end_of_input) begin
                  res_valid  = 1'b1;
                  res_status = ST_CLEAN;
               end else begin
                  if (seen_ff != 16'hFFFF) begin
                     seen_in = seen_ff + 16'd1;
                  end
                  phase_in = PH_COLON;
               end
            end
            PH_COLON: begin
               if (req_data.end_of_input || req_data.ch != COLON_CHAR) begin
                  res_valid  = 1'b1;
                  res_status = ST_NOCOLON;
                  res_fields = 1'b0;
               end else begin
                  count_in   = '0;
                  address_in = '0;
                  type_in    = '0;
                  left_in    = '0;
                  sum_in     = '0;
                  digit_in   = '0;
                  high_in    = '0;
                  phase_in   = PH_COUNT;
               end
            end
            default: begin
               if (req_data.end_of_input) begin
                  // input ran out inside a record
                  res_valid  = 1'b1;
                  res_status = ST_TRUNC;
               end else if (phase_ff == PH_ADDR) begin
                  // address comes in as four digits, high first
                  address_in = addr_shift;
                  digit_in   = digit_ff + 2'd1;
                  if (digit_ff == 2'd3) begin
                     sum_in   = sum_ff + addr_shift[15:8] + addr_shift[7:0];
                     digit_in = '0;
                     phase_in = PH_TYPE;
                  end
               end else if (digit_ff == 2'd0) begin
                  high_in  = nib;
                  digit_in = 2'd1;
               end else begin
                  digit_in = '0;
                  unique case (phase_ff)
                     PH_COUNT: begin
                        count_in = byte_val;
                        left_in  = byte_val;
                        sum_in   = sum_ff + byte_val;
                        phase_in = PH_ADDR;
                     end
                     PH_TYPE: begin
                        type_in = byte_val;
                        sum_in  = sum_ff + byte_val;
                        if (byte_val >= TYPE_LIMIT) begin
                           res_valid  = 1'b1;
                           res_status = ST_BADTYPE;
                        end else begin
                           phase_in = (left_ff != 8'd0) ? PH_DATA : PH_CSUM;
                        end
                     end
                     PH_DATA: begin
                        sum_in  = sum_ff + byte_val;
                        left_in = left_ff - 8'd1;
                        if (left_ff == 8'd1) begin
                           phase_in = PH_CSUM;
                        end
                     end
                     PH_CSUM: begin
                        // good record sums to zero including the checksum
                        res_valid = 1'b1;
                        if (8'(sum_ff + byte_val) != 8'd0) begin
                           res_status = ST_CSUM;
                        end else if (type_ff == TYPE_END) begin
                           res_status = ST_END;
                        end else begin
                           res_status = ST_OK;
                           phase_in   = PH_TERM;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         endcase
         if (res_valid && res_status != ST_OK) begin
            halted_in = 1'b1;
         end
      end
   end

   // report assembled from the fields captured so far, type byte included; fields are zero for a missing colon
   always_comb begin
      res.status        = res_status;
      res.record_number = (seen_ff == 16'hFFFF) ? 16'hFFFF : seen_ff + 16'd1;
      res.record_kind   = res_fields ? type_in : 8'd0;
      res.load_address  = res_fields ? address_ff : 16'd0;
      res.byte_count    = res_fields ? count_ff : 8'd0;
   end

   // output register with skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_fire && res_valid;
            out_in       = res;
         end
      end else if (req_fire && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_COLON;
         digit_ff      <= '0;
         high_ff       <= '0;
         count_ff      <= '0;
         address_ff    <= '0;
         type_ff       <= '0;
         left_ff       <= '0;
         sum_ff        <= '0;
         seen_ff       <= '0;
         halted_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         digit_ff      <= digit_in;
         high_ff       <= high_in;
         count_ff      <= count_in;
         address_ff    <= address_in;
         type_ff       <= type_in;
         left_ff       <= left_in;
         sum_ff        <= sum_in;
         seen_ff       <= seen_in;
         halted_ff     <= halted_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`include "hex_record_stream_checker_top_assert.svh"

   // skid entry only fills behind a full output register
   `HRSC_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid entry valid while output register empty")
   // halt holds until reset
   `HRSC_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff,
      "halt cleared without reset")
   // no report once halted
   `HRSC_ASSERT_NOW(a_quiet_when_halted, clock, reset, halted_ff, !res_valid,
      "report raised while halted")
   // any report other than a good record halts the parser
   `HRSC_ASSERT_NEXT(a_error_halts, clock, reset,
      req_fire && res_valid && res_status != ST_OK, halted_ff,
      "parser did not halt after a final report")

endmodule
